// ===== rtl/ecpi_pkg.sv =====
// Shared types for the exact color palette indexer: controller states and command/status groups.
package ecpi_pkg;

	localparam int unsigned ColorW = 24;
	localparam int unsigned IndexW = 8;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CHECK,
		ST_READ,
		ST_CMP
	} ctrl_state_t;

	typedef enum logic [1:0] {
		FIN_MATCH,
		FIN_APPEND,
		FIN_OVF
	} fin_kind_t;

	typedef struct packed {
		logic      load;
		logic      rd_en;
		logic      inc;
		logic      fin;
		fin_kind_t fin_kind;
	} ctrl_cmd_t;

	typedef struct packed {
		logic ovf;
		logic at_end;
		logic full;
		logic match;
	} dp_status_t;

endpackage

// ===== rtl/ecpi_ctrl.sv =====
// Controller state machine that sequences the palette search, append and result strobe.
module ecpi_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  ecpi_pkg::dp_status_t st,
	output ecpi_pkg::ctrl_cmd_t  cmd,
	output logic                busy
);

	ecpi_pkg::ctrl_state_t state_q;
	ecpi_pkg::ctrl_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ecpi_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ecpi_pkg::ST_IDLE: begin
				if (start) begin
					state_d = ecpi_pkg::ST_CHECK;
				end
			end
			ecpi_pkg::ST_CHECK: begin
				if (st.ovf || st.at_end) begin
					state_d = ecpi_pkg::ST_IDLE;
				end else begin
					state_d = ecpi_pkg::ST_READ;
				end
			end
			ecpi_pkg::ST_READ: begin
				state_d = ecpi_pkg::ST_CMP;
			end
			ecpi_pkg::ST_CMP: begin
				if (st.match) begin
					state_d = ecpi_pkg::ST_IDLE;
				end else begin
					state_d = ecpi_pkg::ST_CHECK;
				end
			end
			default: begin
				state_d = ecpi_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd          = '0;
		cmd.fin_kind = ecpi_pkg::FIN_MATCH;
		busy         = 1'b1;
		unique case (state_q)
			ecpi_pkg::ST_IDLE: begin
				busy     = 1'b0;
				cmd.load = start;
			end
			ecpi_pkg::ST_CHECK: begin
				if (st.ovf) begin
					cmd.fin      = 1'b1;
					cmd.fin_kind = ecpi_pkg::FIN_OVF;
				end else if (st.at_end) begin
					cmd.fin      = 1'b1;
					cmd.fin_kind = st.full ? ecpi_pkg::FIN_OVF : ecpi_pkg::FIN_APPEND;
				end
			end
			ecpi_pkg::ST_READ: begin
				cmd.rd_en = 1'b1;
			end
			ecpi_pkg::ST_CMP: begin
				if (st.match) begin
					cmd.fin      = 1'b1;
					cmd.fin_kind = ecpi_pkg::FIN_MATCH;
				end else begin
					cmd.inc = 1'b1;
				end
			end
			default: begin
				busy = 1'b1;
			end
		endcase
	end

endmodule

// ===== rtl/ecpi_datapath.sv =====
// Datapath with the palette memory, scan counter, fill count, overflow flag and result registers.
module ecpi_datapath #(
	parameter int unsigned PALETTE_ENTRIES = 256
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  ecpi_pkg::ctrl_cmd_t           cmd,
	input  logic [7:0]                   red,
	input  logic [7:0]                   green,
	input  logic [7:0]                   blue,
	input  logic                         last_pixel,
	output ecpi_pkg::dp_status_t          st,
	output logic                         done,
	output logic [ecpi_pkg::IndexW-1:0]  color_index,
	output logic                         added_new,
	output logic                         overflow,
	output logic                         image_done
);

	localparam int unsigned AddrW  = $clog2(PALETTE_ENTRIES);
	localparam int unsigned CountW = $clog2(PALETTE_ENTRIES + 1);

	logic [ecpi_pkg::ColorW-1:0] mem [PALETTE_ENTRIES];
	logic [ecpi_pkg::ColorW-1:0] color_q;
	logic [ecpi_pkg::ColorW-1:0] rd_q;
	logic                        last_q;
	logic [CountW-1:0]           idx_q;
	logic [CountW-1:0]           used_q;
	logic                        ovf_q;
	logic                        done_q;
	logic [ecpi_pkg::IndexW-1:0] index_q;
	logic                        added_q;
	logic                        ovf_out_q;
	logic                        image_done_q;

	assign st.ovf    = ovf_q;
	assign st.at_end = (idx_q == used_q);
	assign st.full   = (used_q == CountW'(PALETTE_ENTRIES));
	assign st.match  = (rd_q == color_q);

	always_ff @(posedge clk) begin
		if (cmd.fin && cmd.fin_kind == ecpi_pkg::FIN_APPEND) begin
			mem[used_q[AddrW-1:0]] <= color_q;
		end
		if (cmd.rd_en) begin
			rd_q <= mem[idx_q[AddrW-1:0]];
		end
		if (cmd.load) begin
			color_q <= {red, green, blue};
			last_q  <= last_pixel;
		end
		if (cmd.fin) begin
			image_done_q <= last_q;
			unique case (cmd.fin_kind)
				ecpi_pkg::FIN_MATCH: begin
					index_q   <= ecpi_pkg::IndexW'(idx_q[AddrW-1:0]);
					added_q   <= 1'b0;
					ovf_out_q <= 1'b0;
				end
				ecpi_pkg::FIN_APPEND: begin
					index_q   <= ecpi_pkg::IndexW'(used_q[AddrW-1:0]);
					added_q   <= 1'b1;
					ovf_out_q <= 1'b0;
				end
				default: begin
					index_q   <= '0;
					added_q   <= 1'b0;
					ovf_out_q <= 1'b1;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q  <= '0;
			used_q <= '0;
			ovf_q  <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.fin;
			if (cmd.load) begin
				idx_q <= '0;
			end else if (cmd.inc) begin
				idx_q <= idx_q + CountW'(1);
			end
			if (cmd.fin) begin
				if (last_q) begin
					used_q <= '0;
					ovf_q  <= 1'b0;
				end else if (cmd.fin_kind == ecpi_pkg::FIN_APPEND) begin
					used_q <= used_q + CountW'(1);
				end else if (cmd.fin_kind == ecpi_pkg::FIN_OVF) begin
					ovf_q <= 1'b1;
				end
			end
		end
	end

	assign done        = done_q;
	assign color_index = index_q;
	assign added_new   = added_q;
	assign overflow    = ovf_out_q;
	assign image_done  = image_done_q;

endmodule

// ===== rtl/exact_color_palette_indexer.sv =====
// Top level of the exact color palette indexer: controller plus datapath.
//
// A pixel transaction is accepted on a rising edge with start high and busy low;
// red, green, blue and last_pixel are sampled then. busy stays high while the
// pixel is searched against the palette, which sits in a single-port memory
// read one entry at a time. Each stored entry is compared in three steps
// (check, memory read, compare), so a pixel whose color sits at index k finishes
// with the compare of entry k and a new color with the check after the last of
// the stored colors. Once overflow is set the pixel finishes in the check step.
// The result appears in the cycle after the search ends, for exactly one cycle,
// marked by done; the receiver cannot stall it, and a new pixel may be started
// in that same cycle. The next start may follow as soon as busy falls.
// A pixel with last_pixel high empties the palette and clears overflow after
// its result is formed. Reset clears the fill count, the overflow flag and the
// controller; the palette memory itself is not cleared, since only entries
// below the fill count are ever read.
module exact_color_palette_indexer #(
	parameter int unsigned PALETTE_ENTRIES = 256
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  logic [7:0] red,
	input  logic [7:0] green,
	input  logic [7:0] blue,
	input  logic       last_pixel,
	output logic       done,
	output logic [7:0] color_index,
	output logic       added_new,
	output logic       overflow,
	output logic       image_done
);

	ecpi_pkg::ctrl_cmd_t  cmd;
	ecpi_pkg::dp_status_t st;

	ecpi_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.st     (st),
		.cmd    (cmd),
		.busy   (busy)
	);

	ecpi_datapath #(
		.PALETTE_ENTRIES (PALETTE_ENTRIES)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.red         (red),
		.green       (green),
		.blue        (blue),
		.last_pixel  (last_pixel),
		.st          (st),
		.done        (done),
		.color_index (color_index),
		.added_new   (added_new),
		.overflow    (overflow),
		.image_done  (image_done)
	);

endmodule
